// File: src/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg: shared types and constants of the force contact detector
// Request and response payloads, the configuration record, register indexes
// and the fixed-point constants of the gravity compensation.
// ----------------------------------------------------------------------------
package fcd_pkg;

  // Default width of the compensated force and of the bias registers
  localparam int FORCE_WIDTH_DEF = 24;

  // Field widths of the request and response payloads
  localparam int FIELD_FW   = 24;
  localparam int DOWN_W     = 16;
  localparam int MASS_W     = 16;
  localparam int THR_W      = 23;
  localparam int SENSE_W    = 2;
  localparam int CAL_W      = 12;
  localparam int CNT_W      = 13;
  localparam int STATUS_W   = 2;
  localparam int FLAG_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_TOOL_MASS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_XN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_XP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_YN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_YP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 3'd7;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // 9.81 in Q16, and one half of the 2^32 scaling for rounding
  localparam logic [MUL_B_W-1:0] GRAV_Q16   = 20'd642908;
  localparam logic [MUL_P_W:0]   ROUND_HALF = 53'd2147483648;
  localparam int WEIGHT_W = MUL_P_W + 1 - 32;  // rounded weight magnitude
  localparam int SUM_W    = 26;                // force plus weight, signed

  // Response codes
  localparam logic [STATUS_W-1:0] STATUS_CAL   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHECK = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMERG = 2'd2;

  localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_TRANS = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_ERROR = 2'd2;

  localparam logic [SENSE_W-1:0] SENSE_IGNORE = 2'd0;
  localparam logic [SENSE_W-1:0] SENSE_TRANS  = 2'd1;

  // Reset values of the registers
  localparam logic [THR_W-1:0]   THR_RESET   = 23'd256;
  localparam logic [SENSE_W-1:0] SENSE_RESET = 2'd2;
  localparam logic [CAL_W-1:0]   CAL_RESET   = 12'd100;

  typedef struct packed {
    logic                       mode;
    logic signed [FIELD_FW-1:0] force_x;
    logic signed [FIELD_FW-1:0] force_y;
    logic signed [DOWN_W-1:0]   down_x;
    logic signed [DOWN_W-1:0]   down_y;
    logic                       emergency_level;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [FLAG_W-1:0]          contact_flag;
    logic                       stop_self;
    logic                       stop_other_valid;
    logic                       stop_other;
    logic signed [FIELD_FW-1:0] bias_out_x;
    logic signed [FIELD_FW-1:0] bias_out_y;
  } out_rsp_t;

  typedef struct packed {
    logic [MASS_W-1:0]  tool_mass;
    logic [THR_W-1:0]   threshold_x;
    logic [THR_W-1:0]   threshold_y;
    logic [SENSE_W-1:0] sense_x_negative;
    logic [SENSE_W-1:0] sense_x_positive;
    logic [SENSE_W-1:0] sense_y_negative;
    logic [SENSE_W-1:0] sense_y_positive;
    logic [CAL_W-1:0]   calibration_samples;
  } cfg_t;

endpackage

// File: src/fcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fcd_cfg_regs: configuration register file
// Eight write-only registers, written through a plain enable/index/data port.
// ----------------------------------------------------------------------------
module fcd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fcd_pkg::cfg_t                    cfg_o
);

  fcd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tool_mass           <= '0;
      cfg_q.threshold_x         <= fcd_pkg::THR_RESET;
      cfg_q.threshold_y         <= fcd_pkg::THR_RESET;
      cfg_q.sense_x_negative    <= fcd_pkg::SENSE_RESET;
      cfg_q.sense_x_positive    <= fcd_pkg::SENSE_RESET;
      cfg_q.sense_y_negative    <= fcd_pkg::SENSE_RESET;
      cfg_q.sense_y_positive    <= fcd_pkg::SENSE_RESET;
      cfg_q.calibration_samples <= fcd_pkg::CAL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcd_pkg::REG_TOOL_MASS:   cfg_q.tool_mass <= cfg_data_i[fcd_pkg::MASS_W-1:0];
        fcd_pkg::REG_THRESHOLD_X: cfg_q.threshold_x <= cfg_data_i[fcd_pkg::THR_W-1:0];
        fcd_pkg::REG_THRESHOLD_Y: cfg_q.threshold_y <= cfg_data_i[fcd_pkg::THR_W-1:0];
        fcd_pkg::REG_SENSE_XN:    cfg_q.sense_x_negative <= cfg_data_i[fcd_pkg::SENSE_W-1:0];
        fcd_pkg::REG_SENSE_XP:    cfg_q.sense_x_positive <= cfg_data_i[fcd_pkg::SENSE_W-1:0];
        fcd_pkg::REG_SENSE_YN:    cfg_q.sense_y_negative <= cfg_data_i[fcd_pkg::SENSE_W-1:0];
        fcd_pkg::REG_SENSE_YP:    cfg_q.sense_y_positive <= cfg_data_i[fcd_pkg::SENSE_W-1:0];
        fcd_pkg::REG_CAL_SAMPLES: begin
          cfg_q.calibration_samples <= cfg_data_i[fcd_pkg::CAL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/fcd_mult.sv
// ----------------------------------------------------------------------------
// fcd_mult: shared unsigned multiplier with registered product
// Serves the weight terms and the bias-times-count products in turn.
// ----------------------------------------------------------------------------
module fcd_mult (
  input  logic                          clk_i,
  input  logic [fcd_pkg::MUL_A_W-1:0]   a_i,
  input  logic [fcd_pkg::MUL_B_W-1:0]   b_i,
  output logic [fcd_pkg::MUL_P_W-1:0]   p_o
);

  logic [fcd_pkg::MUL_P_W-1:0] p_d;
  logic [fcd_pkg::MUL_P_W-1:0] p_q;

  assign p_d = fcd_pkg::MUL_P_W'(a_i) * fcd_pkg::MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: src/fcd_div.sv
// ----------------------------------------------------------------------------
// fcd_div: iterative restoring divider, one quotient bit per cycle
// Divides a magnitude by a small divisor; the quotient is known to fit in FW
// bits, so only FW steps are run. The sign is applied at the end.
// ----------------------------------------------------------------------------
module fcd_div #(
  parameter int FW    = fcd_pkg::FORCE_WIDTH_DEF,
  parameter int DIV_W = fcd_pkg::CNT_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [FW+DIV_W-1:0]    mag_i,
  input  logic [DIV_W-1:0]       den_i,
  input  logic                   neg_i,
  output logic                   done_o,
  output logic signed [FW-1:0]   quot_o
);

  localparam int STEP_W = $clog2(FW + 1);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [DIV_W-1:0]   rem_q;
  logic [FW-1:0]      sh_q;
  logic [DIV_W-1:0]   den_q;
  logic               neg_q;
  logic [DIV_W:0]     rem_shift;
  logic [DIV_W:0]     rem_sub;
  logic               ge;

  assign rem_shift = {rem_q, sh_q[FW-1]};
  assign rem_sub   = rem_shift - {1'b0, den_q};
  assign ge        = (rem_shift >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(FW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the high part of the dividend is already below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= mag_i[FW+DIV_W-1:FW];
      sh_q  <= mag_i[FW-1:0];
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      sh_q  <= {sh_q[FW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(sh_q) : $signed(sh_q);

endmodule

// File: src/force_contact_detector.sv
// ----------------------------------------------------------------------------
// force_contact_detector: gravity-compensated force contact detection
// Adds back the tool weight, averages a bias during calibration, then checks
// each signed half-axis against its threshold and reaction code.
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  payload
//  request   in_valid_i / in_ready_o / in_req_i   in         fcd_pkg::in_req_t
//  response  out_valid_o / out_ready_i / out_rsp_o out       fcd_pkg::out_rsp_t
//  config    cfg_we_i / cfg_idx_i / cfg_data_i    in         register write
//
//  One request at a time. An emergency request is written into the response
//  register when it is accepted. A checked sample makes four passes through
//  the shared multiplier for the two weight terms, then the compare; a
//  calibration sample adds per axis one multiplier pass for bias times count
//  and FORCE_WIDTH steps of the one-bit-per-cycle divider, which sets the
//  rate. Reset clears the bias, the sample count and the registers to their
//  defaults. in_ready_o is high only while the sequencer is idle; a finished
//  response waits in the sequencer while the output register is still held.
//
module force_contact_detector #(
  parameter int FORCE_WIDTH = fcd_pkg::FORCE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  fcd_pkg::in_req_t                 in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fcd_pkg::out_rsp_t                out_rsp_o,
  input  logic                             cfg_we_i,
  input  logic [fcd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int FW     = FORCE_WIDTH;
  localparam int DIV_W  = fcd_pkg::CNT_W;
  localparam int NUM_W  = FW + DIV_W + 1;
  localparam int MAG_W  = FW + DIV_W;
  localparam int EW     = (FW > fcd_pkg::SUM_W) ? FW : fcd_pkg::SUM_W;
  localparam int BW     = (FW > fcd_pkg::FIELD_FW) ? FW : fcd_pkg::FIELD_FW;
  localparam int CMP_W  = (FW + 2 > fcd_pkg::THR_W + 2) ? FW + 2 : fcd_pkg::THR_W + 2;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MX1    = 4'd1;
  localparam logic [3:0] S_MX2    = 4'd2;
  localparam logic [3:0] S_MY1    = 4'd3;
  localparam logic [3:0] S_MY2    = 4'd4;
  localparam logic [3:0] S_FY     = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_BX_NUM = 4'd7;
  localparam logic [3:0] S_BX_DIV = 4'd8;
  localparam logic [3:0] S_BY_NUM = 4'd9;
  localparam logic [3:0] S_BY_DIV = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0] state_q, state_d;

  fcd_pkg::cfg_t     cfg;
  fcd_pkg::in_req_t  req_q;
  fcd_pkg::out_rsp_t res_q, res_d;
  fcd_pkg::out_rsp_t out_q;
  logic              out_valid_q;

  logic signed [FW-1:0]        bias_x_q, bias_y_q;
  logic [fcd_pkg::CNT_W-1:0]   count_q;
  logic signed [FW-1:0]        fx_q, fy_q;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  fcd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // -------------------------------------------------------------------------
  // Shared multiplier: operands chosen by the sequencer state
  // -------------------------------------------------------------------------
  logic [fcd_pkg::MUL_A_W-1:0] mul_a;
  logic [fcd_pkg::MUL_B_W-1:0] mul_b;
  logic [fcd_pkg::MUL_P_W-1:0] mul_p;
  logic [fcd_pkg::DOWN_W-1:0]  abs_dx, abs_dy;
  logic [FW-1:0]               abs_bx, abs_by;

  assign abs_dx = req_q.down_x[fcd_pkg::DOWN_W-1] ? -req_q.down_x : req_q.down_x;
  assign abs_dy = req_q.down_y[fcd_pkg::DOWN_W-1] ? -req_q.down_y : req_q.down_y;
  assign abs_bx = bias_x_q[FW-1] ? -bias_x_q : bias_x_q;
  assign abs_by = bias_y_q[FW-1] ? -bias_y_q : bias_y_q;

  always_comb begin
    unique case (state_q)
      S_MX1: begin
        mul_a = fcd_pkg::MUL_A_W'(abs_dx);
        mul_b = fcd_pkg::MUL_B_W'(cfg.tool_mass);
      end
      S_MY1: begin
        mul_a = fcd_pkg::MUL_A_W'(abs_dy);
        mul_b = fcd_pkg::MUL_B_W'(cfg.tool_mass);
      end
      S_MX2, S_MY2: begin
        mul_a = mul_p[fcd_pkg::MUL_A_W-1:0];
        mul_b = fcd_pkg::GRAV_Q16;
      end
      S_DECIDE: begin
        mul_a = fcd_pkg::MUL_A_W'(abs_bx);
        mul_b = fcd_pkg::MUL_B_W'(count_q);
      end
      default: begin
        mul_a = fcd_pkg::MUL_A_W'(abs_by);
        mul_b = fcd_pkg::MUL_B_W'(count_q);
      end
    endcase
  end

  fcd_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // -------------------------------------------------------------------------
  // Weight compensation: round the Q32 product, apply the sign of the
  // direction, add to the measured force and saturate to FW bits
  // -------------------------------------------------------------------------
  logic                                  comp_y;
  logic signed [fcd_pkg::FIELD_FW-1:0]   comp_force;
  logic                                  comp_neg;
  logic [fcd_pkg::MUL_P_W:0]             rnd;
  logic [fcd_pkg::WEIGHT_W-1:0]          w_mag;
  logic signed [fcd_pkg::WEIGHT_W:0]     w_pos, w_val;
  logic signed [fcd_pkg::SUM_W-1:0]      sum;
  logic signed [EW-1:0]                  sum_ext, sat_hi, sat_lo;
  logic signed [FW-1:0]                  comp_f;

  assign comp_y     = (state_q == S_FY);
  assign comp_force = comp_y ? req_q.force_y : req_q.force_x;
  assign comp_neg   = comp_y ? req_q.down_y[fcd_pkg::DOWN_W-1]
                             : req_q.down_x[fcd_pkg::DOWN_W-1];
  assign rnd        = {1'b0, mul_p} + fcd_pkg::ROUND_HALF;
  assign w_mag      = rnd[fcd_pkg::MUL_P_W:32];
  assign w_pos      = $signed({1'b0, w_mag});
  assign w_val      = comp_neg ? -w_pos : w_pos;
  assign sum        = fcd_pkg::SUM_W'(comp_force) + fcd_pkg::SUM_W'(w_val);
  assign sum_ext    = EW'(sum);
  assign sat_hi     = $signed({{(EW-FW+1){1'b0}}, {(FW-1){1'b1}}});
  assign sat_lo     = $signed({{(EW-FW+1){1'b1}}, {(FW-1){1'b0}}});

  always_comb begin
    priority if (sum_ext > sat_hi) begin
      comp_f = sat_hi[FW-1:0];
    end else if (sum_ext < sat_lo) begin
      comp_f = sat_lo[FW-1:0];
    end else begin
      comp_f = sum_ext[FW-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Running mean: numerator bias * n + f, divided by n + 1
  // -------------------------------------------------------------------------
  logic                       num_y;
  logic signed [NUM_W-1:0]    prod_s, num;
  logic                       num_bias_neg;
  logic signed [FW-1:0]       num_f;
  logic [NUM_W-1:0]           num_abs;
  logic                       div_start, div_done;
  logic signed [FW-1:0]       div_q;

  assign num_y        = (state_q == S_BY_NUM);
  assign num_bias_neg = num_y ? bias_y_q[FW-1] : bias_x_q[FW-1];
  assign num_f        = num_y ? fy_q : fx_q;
  assign prod_s       = $signed(mul_p[NUM_W-1:0]);
  assign num          = (num_bias_neg ? -prod_s : prod_s) + NUM_W'(num_f);
  assign num_abs      = num[NUM_W-1] ? -num : num;
  assign div_start    = (state_q == S_BX_NUM) || (state_q == S_BY_NUM);

  fcd_div #(
    .FW    (FW),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (num_abs[MAG_W-1:0]),
    .den_i   (count_q + 1'b1),
    .neg_i   (num[NUM_W-1]),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // -------------------------------------------------------------------------
  // Contact check: scan x then y, negative half then positive half; an
  // error contact ends the scan
  // -------------------------------------------------------------------------
  logic signed [FW:0]          dx, dy;
  logic signed [CMP_W-1:0]     dx_c, dy_c, tx_c, ty_c;
  logic [3:0]                  hit;
  logic [3:0][fcd_pkg::SENSE_W-1:0] code;
  logic [fcd_pkg::FLAG_W-1:0]  chk_flag;
  logic                        chk_self, chk_other, chk_stop;

  assign dx   = (FW+1)'(fx_q) - (FW+1)'(bias_x_q);
  assign dy   = (FW+1)'(fy_q) - (FW+1)'(bias_y_q);
  assign dx_c = CMP_W'(dx);
  assign dy_c = CMP_W'(dy);
  assign tx_c = $signed(CMP_W'(cfg.threshold_x));
  assign ty_c = $signed(CMP_W'(cfg.threshold_y));

  assign hit[0]  = dx_c < -tx_c;
  assign hit[1]  = dx_c > tx_c;
  assign hit[2]  = dy_c < -ty_c;
  assign hit[3]  = dy_c > ty_c;
  assign code[0] = cfg.sense_x_negative;
  assign code[1] = cfg.sense_x_positive;
  assign code[2] = cfg.sense_y_negative;
  assign code[3] = cfg.sense_y_positive;

  always_comb begin
    chk_flag  = fcd_pkg::FLAG_NONE;
    chk_self  = 1'b0;
    chk_other = 1'b0;
    chk_stop  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!chk_stop && hit[i] && (code[i] != fcd_pkg::SENSE_IGNORE)) begin
        chk_self = 1'b1;
        if (code[i] == fcd_pkg::SENSE_TRANS) begin
          chk_flag = fcd_pkg::FLAG_TRANS;
        end else begin
          // codes two and three both count as error
          chk_flag  = fcd_pkg::FLAG_ERROR;
          chk_other = 1'b1;
          chk_stop  = 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  logic calibrating;
  logic accept;
  logic out_load;

  assign calibrating = (count_q <= fcd_pkg::CNT_W'(cfg.calibration_samples));
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_req_i.mode) begin
            // emergency: stop or release both arms at once
            res_d.status           = fcd_pkg::STATUS_EMERG;
            res_d.contact_flag     = fcd_pkg::FLAG_ERROR;
            res_d.stop_self        = in_req_i.emergency_level;
            res_d.stop_other_valid = 1'b1;
            res_d.stop_other       = in_req_i.emergency_level;
            state_d                = S_DONE;
          end else begin
            state_d = S_MX1;
          end
        end
      end
      S_MX1:    state_d = S_MX2;
      S_MX2:    state_d = S_MY1;
      S_MY1:    state_d = S_MY2;
      S_MY2:    state_d = S_FY;
      S_FY:     state_d = S_DECIDE;
      S_DECIDE: begin
        if (calibrating) begin
          res_d.status           = fcd_pkg::STATUS_CAL;
          res_d.contact_flag     = fcd_pkg::FLAG_NONE;
          res_d.stop_self        = 1'b0;
          res_d.stop_other_valid = 1'b0;
          res_d.stop_other       = 1'b0;
          state_d                = S_BX_NUM;
        end else begin
          res_d.status           = fcd_pkg::STATUS_CHECK;
          res_d.contact_flag     = chk_flag;
          res_d.stop_self        = chk_self;
          res_d.stop_other_valid = (chk_flag == fcd_pkg::FLAG_ERROR);
          res_d.stop_other       = chk_other;
          state_d                = S_DONE;
        end
      end
      S_BX_NUM: state_d = S_BX_DIV;
      S_BX_DIV: begin
        if (div_done) begin
          state_d = S_BY_NUM;
        end
      end
      S_BY_NUM: state_d = S_BY_DIV;
      S_BY_DIV: begin
        if (div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bias_x_q    <= '0;
      bias_y_q    <= '0;
      count_q     <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // update the bias once its quotient is ready; advance the count last
      if ((state_q == S_BX_DIV) && div_done) begin
        bias_x_q <= div_q;
      end
      if ((state_q == S_BY_DIV) && div_done) begin
        bias_y_q <= div_q;
        count_q  <= count_q + 1'b1;
      end
    end
  end

  // Payload registers: request copy, compensated forces, response
  logic signed [BW-1:0] bx_ext, by_ext;
  fcd_pkg::out_rsp_t    out_d;

  assign bx_ext = BW'(bias_x_q);
  assign by_ext = BW'(bias_y_q);

  // Take the flags from the sequencer and the bias as it stands now
  always_comb begin
    out_d            = res_q;
    out_d.bias_out_x = bx_ext[fcd_pkg::FIELD_FW-1:0];
    out_d.bias_out_y = by_ext[fcd_pkg::FIELD_FW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (state_q == S_MY1) begin
      fx_q <= comp_f;
    end
    if (state_q == S_FY) begin
      fy_q <= comp_f;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
